[rtl/core/swm_pkg.sv]
// Package for the sliding window median filter.
// Holds field widths, parameter defaults, cell control codes and the sequencer states.
// No dependencies.
package swm_pkg;

    localparam int SAMPLE_BITS      = 32;
    localparam int MEDIAN_BITS      = 33;
    localparam int WSIZE_BITS       = 7;
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DROP,
        OP_STEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     has_drop;
        logic     drop_low;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DROP
    } t_state;

endpackage

[rtl/core/swm_ifs.sv]
// Valid/ready channel interfaces for the sliding window median filter.
// Depends on swm_pkg for the field widths.
interface swm_in_if import swm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [MEDIAN_BITS-1:0] median_twice;

    modport source (output valid, output median_twice, input ready);
    modport sink   (input valid, input median_twice, output ready);
endinterface

[rtl/core/swm_cell.sv]
// One cell of the sorted sample row: holds a value and its age.
// Depends on swm_pkg for the cell control struct.
module swm_cell import swm_pkg::*; #(
    parameter int SW    = SAMPLE_WIDTH_DEF,
    parameter int AGE_W = 6
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic signed [SW-1:0] i_sample,
    input  logic                 i_valid,
    input  logic                 i_above_drop,
    input  logic                 i_is_drop,
    input  logic signed [SW-1:0] i_lo_value,
    input  logic [AGE_W-1:0]     i_lo_age,
    input  logic                 i_lo_le,
    input  logic signed [SW-1:0] i_hi_value,
    input  logic [AGE_W-1:0]     i_hi_age,
    input  logic                 i_hi_le,
    output logic signed [SW-1:0] o_value,
    output logic [AGE_W-1:0]     o_age,
    output logic                 o_le
);

    logic signed [SW-1:0] r_value, n_value;
    logic [AGE_W-1:0]     r_age, n_age;
    logic                 le;

    assign le      = i_valid && (r_value <= i_sample);
    assign o_le    = le;
    assign o_value = r_value;
    assign o_age   = r_age;

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        case (i_ctl.op)
            OP_HOLD: begin
                n_value = r_value;
            end
            OP_DROP: begin
                if (i_above_drop || i_is_drop) begin
                    n_value = i_hi_value;
                    n_age   = i_hi_age;
                end
            end
            OP_STEP: begin
                n_age = r_age + AGE_W'(1);
                if (!i_ctl.has_drop) begin
                    if (le) begin
                        n_value = r_value;
                    end else if (i_lo_le) begin
                        n_value = i_sample;
                        n_age   = '0;
                    end else begin
                        n_value = i_lo_value;
                        n_age   = i_lo_age + AGE_W'(1);
                    end
                end else if (i_ctl.drop_low) begin
                    if ((i_above_drop || i_is_drop) && le) begin
                        if (i_hi_le) begin
                            n_value = i_hi_value;
                            n_age   = i_hi_age + AGE_W'(1);
                        end else begin
                            n_value = i_sample;
                            n_age   = '0;
                        end
                    end
                end else begin
                    if (le) begin
                        n_value = r_value;
                    end else if (i_lo_le) begin
                        n_value = i_sample;
                        n_age   = '0;
                    end else if (!i_above_drop) begin
                        n_value = i_lo_value;
                        n_age   = i_lo_age + AGE_W'(1);
                    end
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

[rtl/core/swm_readout.sv]
// Median readout: sums the two middle cells (one cell twice if odd) and holds the word.
// Depends on swm_pkg and the swm_out_if interface.
module swm_readout import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int SW         = SAMPLE_WIDTH_DEF,
    parameter int KW         = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [SW-1:0] i_values [WINDOW_MAX],
    input  logic [KW-1:0]        i_k,
    input  logic                 i_load,
    output logic                 o_slot_free,
    swm_out_if.source            o_out_ch
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [KW-1:0]                 km1;
    logic [IDX_W-1:0]              idx_a, idx_b;
    logic signed [SW-1:0]          val_a, val_b;
    logic signed [MEDIAN_BITS-1:0] sum;
    logic                          r_valid, n_valid;
    logic signed [MEDIAN_BITS-1:0] r_data, n_data;

    assign km1   = i_k - KW'(1);
    assign idx_a = IDX_W'(km1 >> 1);
    assign idx_b = IDX_W'(i_k >> 1);
    assign val_a = i_values[idx_a];
    assign val_b = i_values[idx_b];
    assign sum   = {{(MEDIAN_BITS-SW){val_a[SW-1]}}, val_a}
                 + {{(MEDIAN_BITS-SW){val_b[SW-1]}}, val_b};

    assign o_slot_free           = !r_valid || o_out_ch.ready;
    assign o_out_ch.valid        = r_valid;
    assign o_out_ch.median_twice = r_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_load) begin
            n_valid = 1'b1;
            n_data  = sum;
        end else if (o_out_ch.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

endmodule

[rtl/core/sliding_window_median.sv]
// Sliding window median filter: a row of sorted cells with ages and a median readout.
// A step that fills the window sets a pending flag; the readout then registers the median.
// Throughput: one sample per cycle unless a median word waits on a busy sink; a shrunk
// window holds the next sample while the oldest cells are dropped, one per cycle.
// Reset: window size 3 and an empty window; cell contents are not cleared.
// Depends on swm_pkg, swm_ifs, swm_cell and swm_readout.
module sliding_window_median import swm_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WSIZE_BITS-1:0] i_cfg_wdata,
    swm_in_if.sink                i_in_ch,
    swm_out_if.source             o_out_ch
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int KW    = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int IDX_W = AGE_W;

    t_state                r_state, n_state;
    logic [KW-1:0]         r_fill, n_fill;
    logic signed [SW-1:0]  r_held, n_held;
    logic                  r_res_pend, n_res_pend;
    logic [WSIZE_BITS-1:0] r_wsize;

    logic [KW-1:0]         keff;
    logic [KW-1:0]         eff_fill;
    logic [KW-1:0]         fill_m1;
    logic                  want_drop;
    t_cell_op              op;
    logic signed [SW-1:0]  step_sample;
    logic                  slot_free;
    logic                  cells_free;
    logic                  ro_load;
    logic                  in_acc;
    logic [IDX_W-1:0]      d_idx;
    logic                  drop_low;
    t_cell_ctl             ctl;

    logic signed [SW-1:0]  w_value [WINDOW_MAX];
    logic [AGE_W-1:0]      w_age   [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] w_le;
    logic [WINDOW_MAX-1:0] w_valid;
    logic [WINDOW_MAX-1:0] w_is_drop;
    logic [WINDOW_MAX-1:0] w_above;

    always_comb begin
        if (r_wsize == '0) begin
            keff = KW'(1);
        end else if (32'(r_wsize) > WINDOW_MAX) begin
            keff = KW'(WINDOW_MAX);
        end else begin
            keff = KW'(r_wsize);
        end
    end

    assign cells_free      = !r_res_pend || slot_free;
    assign ro_load         = r_res_pend && slot_free;
    assign i_in_ch.ready   = (r_state == ST_IDLE) && cells_free;
    assign in_acc          = i_in_ch.valid && i_in_ch.ready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_held      = r_held;
        n_res_pend  = r_res_pend;
        op          = OP_HOLD;
        eff_fill    = r_fill;
        step_sample = r_held;
        want_drop   = 1'b0;
        if (ro_load) begin
            n_res_pend = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_in_ch.restart && (r_fill > keff)) begin
                        op        = OP_DROP;
                        want_drop = 1'b1;
                        n_fill    = r_fill - KW'(1);
                        n_held    = i_in_ch.sample[SW-1:0];
                        n_state   = ST_DROP;
                    end else begin
                        op          = OP_STEP;
                        step_sample = i_in_ch.sample[SW-1:0];
                        eff_fill    = i_in_ch.restart ? '0 : r_fill;
                        want_drop   = (eff_fill >= keff);
                        n_fill      = want_drop ? eff_fill : eff_fill + KW'(1);
                        n_res_pend  = (n_fill == keff);
                    end
                end
            end
            ST_DROP: begin
                if (cells_free) begin
                    if (r_fill > keff) begin
                        op        = OP_DROP;
                        want_drop = 1'b1;
                        n_fill    = r_fill - KW'(1);
                    end else begin
                        op         = OP_STEP;
                        want_drop  = (r_fill >= keff);
                        n_fill     = want_drop ? r_fill : r_fill + KW'(1);
                        n_res_pend = (n_fill == keff);
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign fill_m1 = eff_fill - KW'(1);

    always_comb begin
        d_idx    = '0;
        drop_low = 1'b0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_valid[i]   = (32'(i) < 32'(eff_fill));
            w_is_drop[i] = want_drop && w_valid[i] && (w_age[i] == AGE_W'(fill_m1));
            if (w_is_drop[i]) begin
                d_idx = d_idx | IDX_W'(i);
            end
            drop_low = drop_low | (w_is_drop[i] & w_le[i]);
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_above[i] = want_drop && (32'(i) > 32'(d_idx));
        end
    end

    assign ctl.op       = op;
    assign ctl.has_drop = want_drop;
    assign ctl.drop_low = drop_low;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic signed [SW-1:0] lo_value, hi_value;
        logic [AGE_W-1:0]     lo_age, hi_age;
        logic                 lo_le, hi_le;

        if (g == 0) begin : g_first
            assign lo_value = '0;
            assign lo_age   = '0;
            assign lo_le    = 1'b1;
        end else begin : g_mid_lo
            assign lo_value = w_value[g-1];
            assign lo_age   = w_age[g-1];
            assign lo_le    = w_le[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_last
            assign hi_value = '0;
            assign hi_age   = '0;
            assign hi_le    = 1'b0;
        end else begin : g_mid_hi
            assign hi_value = w_value[g+1];
            assign hi_age   = w_age[g+1];
            assign hi_le    = w_le[g+1];
        end

        swm_cell #(
            .SW    (SW),
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_sample     (step_sample),
            .i_valid      (w_valid[g]),
            .i_above_drop (w_above[g]),
            .i_is_drop    (w_is_drop[g]),
            .i_lo_value   (lo_value),
            .i_lo_age     (lo_age),
            .i_lo_le      (lo_le),
            .i_hi_value   (hi_value),
            .i_hi_age     (hi_age),
            .i_hi_le      (hi_le),
            .o_value      (w_value[g]),
            .o_age        (w_age[g]),
            .o_le         (w_le[g])
        );
    end

    swm_readout #(
        .WINDOW_MAX (WINDOW_MAX),
        .SW         (SW),
        .KW         (KW)
    ) u_readout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_values    (w_value),
        .i_k         (keff),
        .i_load      (ro_load),
        .o_slot_free (slot_free),
        .o_out_ch    (o_out_ch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_res_pend <= 1'b0;
            r_wsize    <= WSIZE_RESET;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_res_pend <= n_res_pend;
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
            end
        end
        r_held <= n_held;
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= WINDOW_MAX)
        else $error("window fill count above the store depth");

    a_one_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_is_drop))
        else $error("more than one cell marked for removal");

    a_drop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        want_drop |-> $onehot(w_is_drop))
        else $error("no cell holds the oldest sample");

    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_pend |-> (r_fill == keff))
        else $error("median pending while the window is not full");

    a_step_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == OP_STEP && want_drop) |=> (r_fill == $past(r_fill)))
        else $error("fill count moved on a step that drops one sample");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the sliding window median filter, driving both channels.
// A directed table runs first, then random phases under several window sizes.
// Depends on swm_pkg, swm_ifs and the sliding_window_median RTL.
module tb_top import swm_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES = 14;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh80000000;
    localparam logic signed [MEDIAN_BITS-1:0] M_ZERO = 33'sh000000000;
    localparam logic signed [MEDIAN_BITS-1:0] M_MAX2 = 33'sh0FFFFFFFE;
    localparam logic signed [MEDIAN_BITS-1:0] M_MIN2 = 33'sh100000000;
    localparam logic signed [MEDIAN_BITS-1:0] M_NEG1 = 33'sh1FFFFFFFF;

    typedef struct {
        bit                            is_cfg;
        logic [WSIZE_BITS-1:0]         wsize;
        logic signed [SAMPLE_BITS-1:0] sample;
        bit                            restart;
        bit                            typed;
        logic signed [MEDIAN_BITS-1:0] twice;
    } t_step_row;

    t_step_row dir_rows [26] = '{
        '{1'b0, 7'd0,   S_MIN, 1'b1, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   S_MAX, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   32'sd0, 1'b0, 1'b1, M_ZERO},
        '{1'b0, 7'd0,   S_MAX, 1'b0, 1'b1, M_MAX2},
        '{1'b0, 7'd0,   S_MAX, 1'b0, 1'b1, M_MAX2},
        '{1'b0, 7'd0,   S_MIN, 1'b0, 1'b1, M_MAX2},
        '{1'b0, 7'd0,   S_MIN, 1'b0, 1'b1, M_MIN2},
        '{1'b0, 7'd0,   32'sd5, 1'b1, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   32'sd7, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   32'sd6, 1'b0, 1'b1, 33'sd12},
        '{1'b1, 7'd2,   32'sd0, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   -32'sd1, 1'b0, 1'b1, 33'sd5},
        '{1'b0, 7'd0,   S_MIN, 1'b1, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   S_MAX, 1'b0, 1'b1, M_NEG1},
        '{1'b1, 7'd0,   32'sd0, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   S_MIN, 1'b0, 1'b1, M_MIN2},
        '{1'b0, 7'd0,   S_MAX, 1'b0, 1'b1, M_MAX2},
        '{1'b0, 7'd0,   32'sd0, 1'b1, 1'b1, M_ZERO},
        '{1'b1, 7'd127, 32'sd0, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   -32'sd3, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   -32'sd3, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   -32'sd3, 1'b0, 1'b0, M_ZERO},
        '{1'b1, 7'd4,   32'sd0, 1'b0, 1'b0, M_ZERO},
        '{1'b0, 7'd0,   -32'sd3, 1'b0, 1'b1, -33'sd6},
        '{1'b0, 7'd0,   32'sd2, 1'b0, 1'b1, -33'sd6},
        '{1'b0, 7'd0,   32'sd2, 1'b0, 1'b0, M_ZERO}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we;
    logic [WSIZE_BITS-1:0] cfg_wdata;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    sliding_window_median dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    logic [WSIZE_BITS-1:0]         window_reg;
    logic signed [SAMPLE_BITS-1:0] win_vals [WINDOW_MAX_DEF];
    int                            win_ages [WINDOW_MAX_DEF];
    int                            win_fill;

    logic signed [MEDIAN_BITS-1:0] median_q [$];
    logic signed [MEDIAN_BITS-1:0] median_exp;
    int fail_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (median_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 30)
                    $display("%0t: median word with none pending, expected none, got %0d",
                             $time, out_ch.median_twice);
            end else begin
                median_exp = median_q.pop_front();
                if (out_ch.median_twice !== median_exp) begin
                    fail_count++;
                    if (fail_count <= 30)
                        $display("%0t: median_twice mismatch, expected %0d, got %0d",
                                 $time, median_exp, out_ch.median_twice);
                end
            end
        end
    end

    // Drops samples that leave the window, inserts the new one after equal values,
    // and returns 1 with twice the median once the window is exactly full.
    function automatic bit median_step(input logic signed [SAMPLE_BITS-1:0] x,
                                       input bit new_seq,
                                       output logic signed [MEDIAN_BITS-1:0] twice);
        int k;
        int j;
        int pos;
        logic signed [MEDIAN_BITS-1:0] lo;
        logic signed [MEDIAN_BITS-1:0] hi;
        k = (window_reg == 0) ? 1 :
            (int'(window_reg) > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(window_reg);
        if (new_seq)
            win_fill = 0;
        j = 0;
        for (int i = 0; i < win_fill; i++) begin
            if (win_ages[i] + 1 < k) begin
                win_vals[j] = win_vals[i];
                win_ages[j] = win_ages[i] + 1;
                j++;
            end
        end
        win_fill = j;
        pos = 0;
        while (pos < win_fill && win_vals[pos] <= x)
            pos++;
        for (int i = win_fill; i > pos; i--) begin
            win_vals[i] = win_vals[i - 1];
            win_ages[i] = win_ages[i - 1];
        end
        win_vals[pos] = x;
        win_ages[pos] = 0;
        win_fill++;
        twice = '0;
        if (win_fill != k)
            return 1'b0;
        if (k % 2 == 1) begin
            lo = win_vals[(k - 1) / 2];
            hi = lo;
        end else begin
            lo = win_vals[k / 2 - 1];
            hi = win_vals[k / 2];
        end
        twice = lo + hi;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_sample = $urandom;
            4, 5, 6:    pick_sample = int'($urandom_range(0, 8)) - 4;
            7:          pick_sample = $urandom_range(0, 1) ? S_MAX : S_MIN;
            8:          pick_sample = S_MAX - $urandom_range(0, 3);
            default:    pick_sample = S_MIN + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input bit r,
                             input bit typed, input logic signed [MEDIAN_BITS-1:0] typed_val);
        logic signed [MEDIAN_BITS-1:0] pred;
        bit got;
        if (idle_on && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 11));
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= r;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        got = median_step(s, r, pred);
        if (typed)
            median_q = {median_q, typed_val};
        else if (got)
            median_q = {median_q, pred};
    endtask

    // The filter must be idle before the window size changes, so every pending
    // word is collected first and the pipeline is given time to settle.
    task automatic write_window(input logic [WSIZE_BITS-1:0] w);
        idle_for(1);
        while (median_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        window_reg = w;
    endtask

    initial begin
        int n_items;
        logic [WSIZE_BITS-1:0] w;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.restart = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        window_reg    = WSIZE_RESET;
        win_fill      = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                write_window(dir_rows[r].wsize);
            else
                send_word(dir_rows[r].sample, dir_rows[r].restart,
                          dir_rows[r].typed, dir_rows[r].twice);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       w = 7'd64;
                1:       w = 7'd5;
                2:       w = 7'd0;
                3:       w = 7'd127;
                4:       w = 7'd2;
                5:       w = 7'd1;
                6:       w = 7'd65;
                default: w = ($urandom_range(0, 5) == 0) ? 7'($urandom) :
                                                           7'($urandom_range(1, 12));
            endcase
            write_window(w);
            idle_on = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            n_items = (w > 7'd32) ? 100 : $urandom_range(30, 60);
            for (int i = 0; i < n_items; i++)
                send_word(pick_sample(),
                          (i == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0),
                          1'b0, M_ZERO);
        end

        idle_for(1);
        while (median_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && median_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
